>>> rtl/cds_pkg.sv
// Shared types, codes and calendar functions for the calendar date stepper.
package cds_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;

	localparam int YEAR_MAX = 9999;

	localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(12);
	localparam logic [DAY_W-1:0]   DAY_FIRST   = DAY_W'(1);
	localparam logic [DAY_W-1:0]   DAY_LAST    = DAY_W'(31);

	localparam logic [YEAR_W-1:0]  RESET_YEAR  = YEAR_W'(2000);

	// floor(y / 100) == (y * 5243) >> 19 for every 14-bit year
	localparam int RECIP_W = 13;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
	localparam int RECIP_SH = 19;
	localparam int PROD_W = YEAR_W + RECIP_W;
	// multiples of 100 leave a fraction of 12*(y/100), below this bound
	localparam int FRAC_LIMIT_SH = 11;

	typedef logic [YEAR_W-1:0]  year_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DAY_W-1:0]   day_t;

	typedef enum logic [1:0] {
		OP_SET     = 2'd0,
		OP_NEXT    = 2'd1,
		OP_PREV    = 2'd2,
		OP_COMPARE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_MONTH = 2'd1,
		ST_BAD_DAY   = 2'd2,
		ST_LIMIT     = 2'd3
	} status_t;

	function automatic logic leap_year(input year_t y);
		logic [PROD_W-1:0] prod;
		logic              div100;
		prod   = PROD_W'(y) * PROD_W'(RECIP_100);
		div100 = (prod[RECIP_SH-1:FRAC_LIMIT_SH] == '0);
		// divisible by 400: quotient by 100 also divisible by 4
		return (y[1:0] == 2'b00) && (!div100 || (prod[RECIP_SH+1:RECIP_SH] == 2'b00));
	endfunction

	function automatic day_t month_len(input logic leap, input month_t m);
		day_t len;
		case (m) inside
			4'd2:                  len = leap ? DAY_W'(29) : DAY_W'(28);
			4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
			default:               len = DAY_LAST;
		endcase
		return len;
	endfunction

endpackage

>>> rtl/cds_if.sv
// Command and result channel interfaces of the calendar date stepper.
interface cds_cmd_if;
	logic             valid;
	logic             ready;
	cds_pkg::op_t     opcode;
	cds_pkg::year_t   year_in;
	cds_pkg::month_t  month_in;
	cds_pkg::day_t    day_in;

	modport source (output valid, opcode, year_in, month_in, day_in, input ready);
	modport sink   (input valid, opcode, year_in, month_in, day_in, output ready);
endinterface

interface cds_res_if;
	logic              valid;
	logic              ready;
	cds_pkg::year_t    year_out;
	cds_pkg::month_t   month_out;
	cds_pkg::day_t     day_out;
	cds_pkg::status_t  status;
	logic              is_before;
	logic              is_equal;

	modport source (output valid, year_out, month_out, day_out, status, is_before, is_equal,
		input ready);
	modport sink   (input valid, year_out, month_out, day_out, status, is_before, is_equal,
		output ready);
endinterface

>>> rtl/calendar_date_stepper.sv
// Calendar date stepper: holds a Gregorian date and applies set, step and compare commands.
// Path from command accept to result valid: the input register, then the result register.
// Throughput: one command per cycle; the date register updates as each result is loaded,
// so the following command sees it with no bubble. The result register stalls only on res.ready.
// Reset: arst_n clears both stages and sets the date to 2000-01-01.
module calendar_date_stepper #(
	parameter int YEAR_MAX = cds_pkg::YEAR_MAX
) (
	input  logic         clk,
	input  logic         arst_n,
	cds_cmd_if.sink      cmd,
	cds_res_if.source    res
);

	localparam cds_pkg::year_t YEAR_LIMIT = cds_pkg::YEAR_W'(YEAR_MAX);

	// input stage
	logic              valid_s1;
	cds_pkg::op_t      op_s1;
	cds_pkg::year_t    year_s1;
	cds_pkg::month_t   month_s1;
	cds_pkg::day_t     day_s1;
	logic              leap_s1;

	// stored date
	cds_pkg::year_t    cur_year_q;
	cds_pkg::month_t   cur_month_q;
	cds_pkg::day_t     cur_day_q;

	// result register
	logic              res_valid_q;
	cds_pkg::status_t  res_status_q;
	logic              res_before_q;
	logic              res_equal_q;

	logic              out_adv;
	logic              fire_s1;

	logic              cur_leap;
	cds_pkg::day_t     cur_len;
	cds_pkg::day_t     prev_len;
	cds_pkg::day_t     set_len;

	cds_pkg::year_t    nxt_year;
	cds_pkg::month_t   nxt_month;
	cds_pkg::day_t     nxt_day;
	cds_pkg::status_t  nxt_status;
	logic              nxt_before;
	logic              nxt_equal;

	assign out_adv   = !res_valid_q || res.ready;
	assign fire_s1   = valid_s1 && out_adv;
	assign cmd.ready = !valid_s1 || out_adv;

	assign cur_leap = cds_pkg::leap_year(cur_year_q);
	assign cur_len  = cds_pkg::month_len(cur_leap, cur_month_q);
	assign prev_len = cds_pkg::month_len(cur_leap, cur_month_q - cds_pkg::MONTH_FIRST);
	assign set_len  = cds_pkg::month_len(leap_s1, month_s1);

	always_comb begin
		nxt_year   = cur_year_q;
		nxt_month  = cur_month_q;
		nxt_day    = cur_day_q;
		nxt_status = cds_pkg::ST_OK;
		nxt_before = 1'b0;
		nxt_equal  = 1'b0;
		case (op_s1)
			cds_pkg::OP_SET: begin
				if (year_s1 > YEAR_LIMIT) begin
					nxt_status = cds_pkg::ST_LIMIT;
				end else if (month_s1 < cds_pkg::MONTH_FIRST || month_s1 > cds_pkg::MONTH_LAST) begin
					nxt_status = cds_pkg::ST_BAD_MONTH;
				end else if (day_s1 < cds_pkg::DAY_FIRST || day_s1 > set_len) begin
					nxt_status = cds_pkg::ST_BAD_DAY;
				end else begin
					nxt_year  = year_s1;
					nxt_month = month_s1;
					nxt_day   = day_s1;
				end
			end
			cds_pkg::OP_NEXT: begin
				if (cur_day_q < cur_len) begin
					nxt_day = cur_day_q + cds_pkg::DAY_FIRST;
				end else if (cur_month_q < cds_pkg::MONTH_LAST) begin
					nxt_month = cur_month_q + cds_pkg::MONTH_FIRST;
					nxt_day   = cds_pkg::DAY_FIRST;
				end else if (cur_year_q < YEAR_LIMIT) begin
					nxt_year  = cur_year_q + cds_pkg::YEAR_W'(1);
					nxt_month = cds_pkg::MONTH_FIRST;
					nxt_day   = cds_pkg::DAY_FIRST;
				end else begin
					nxt_status = cds_pkg::ST_LIMIT;
				end
			end
			cds_pkg::OP_PREV: begin
				if (cur_day_q > cds_pkg::DAY_FIRST) begin
					nxt_day = cur_day_q - cds_pkg::DAY_FIRST;
				end else if (cur_month_q > cds_pkg::MONTH_FIRST) begin
					nxt_month = cur_month_q - cds_pkg::MONTH_FIRST;
					nxt_day   = prev_len;
				end else if (cur_year_q != '0) begin
					nxt_year  = cur_year_q - cds_pkg::YEAR_W'(1);
					nxt_month = cds_pkg::MONTH_LAST;
					nxt_day   = cds_pkg::DAY_LAST;
				end else begin
					nxt_status = cds_pkg::ST_LIMIT;
				end
			end
			default: begin
				// raw field compare: year, then month, then day
				if (cur_year_q != year_s1) begin
					nxt_before = cur_year_q < year_s1;
				end else if (cur_month_q != month_s1) begin
					nxt_before = cur_month_q < month_s1;
				end else begin
					nxt_before = cur_day_q < day_s1;
				end
				nxt_equal = (cur_year_q == year_s1) && (cur_month_q == month_s1)
					&& (cur_day_q == day_s1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// leap flag of the supplied year is worked out on the way in
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1    <= cmd.opcode;
			year_s1  <= cmd.year_in;
			month_s1 <= cmd.month_in;
			day_s1   <= cmd.day_in;
			leap_s1  <= cds_pkg::leap_year(cmd.year_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q  <= cds_pkg::RESET_YEAR;
			cur_month_q <= cds_pkg::MONTH_FIRST;
			cur_day_q   <= cds_pkg::DAY_FIRST;
			res_valid_q <= 1'b0;
		end else begin
			if (out_adv) begin
				res_valid_q <= valid_s1;
			end
			if (fire_s1) begin
				cur_year_q  <= nxt_year;
				cur_month_q <= nxt_month;
				cur_day_q   <= nxt_day;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_status_q <= nxt_status;
			res_before_q <= nxt_before;
			res_equal_q  <= nxt_equal;
		end
	end

	// the stored date doubles as the result date: it changes only when a word is loaded
	assign res.valid     = res_valid_q;
	assign res.year_out  = cur_year_q;
	assign res.month_out = cur_month_q;
	assign res.day_out   = cur_day_q;
	assign res.status    = res_status_q;
	assign res.is_before = res_before_q;
	assign res.is_equal  = res_equal_q;

endmodule

>>> verif/tb_calendar_date_stepper.sv
// Self-checking testbench for the calendar date stepper: directed and random command words.
`timescale 1ns / 1ps

module tb_calendar_date_stepper;

	localparam int CYCLE_LIMIT   = 20000;
	localparam int RANDOM_WORDS  = 400;
	localparam int IDLE_PCT      = 26;
	localparam int HOLDOFF_AFTER = 250;
	localparam int HOLDOFF_LEN   = 80;
	localparam int TAIL_CYCLES   = 8;

	typedef struct packed {
		cds_pkg::op_t    opcode;
		cds_pkg::year_t  year;
		cds_pkg::month_t month;
		cds_pkg::day_t   day;
		logic            drain;
	} cmd_word_t;

	typedef struct packed {
		cds_pkg::year_t   year;
		cds_pkg::month_t  month;
		cds_pkg::day_t    day;
		cds_pkg::status_t status;
		logic             earlier;
		logic             equal;
	} date_reply_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cds_cmd_if cmd_bus ();
	cds_res_if res_bus ();

	calendar_date_stepper u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	always #2 clk = ~clk;

	cmd_word_t   pending_words[$];
	date_reply_t replies_due[$];

	cds_pkg::year_t  held_year  = cds_pkg::RESET_YEAR;
	cds_pkg::month_t held_month = cds_pkg::MONTH_FIRST;
	cds_pkg::day_t   held_day   = cds_pkg::DAY_FIRST;

	int   errors        = 0;
	int   cycle_count   = 0;
	int   words_sent    = 0;
	int   random_start  = -1;
	int   holdoff_left  = 0;
	logic holdoff_done  = 1'b0;
	logic calm;

	// no idling on either side while this window of words goes through
	assign calm = (words_sent >= 100) && (words_sent < 200);

	function automatic logic is_leap(int y);
		if (y % 400 == 0)
			return 1'b1;
		if (y % 100 == 0)
			return 1'b0;
		return (y % 4 == 0);
	endfunction

	function automatic int days_in(int y, int m);
		if (m == 2)
			return is_leap(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic date_reply_t apply_command(cds_pkg::op_t op, cds_pkg::year_t y,
			cds_pkg::month_t m, cds_pkg::day_t d);
		date_reply_t r;
		r.status  = cds_pkg::ST_OK;
		r.earlier = 1'b0;
		r.equal   = 1'b0;
		case (op)
			cds_pkg::OP_SET: begin
				if (int'(y) > cds_pkg::YEAR_MAX)
					r.status = cds_pkg::ST_LIMIT;
				else if (m < 1 || m > 12)
					r.status = cds_pkg::ST_BAD_MONTH;
				else if (d < 1 || int'(d) > days_in(int'(y), int'(m)))
					r.status = cds_pkg::ST_BAD_DAY;
				else begin
					held_year  = y;
					held_month = m;
					held_day   = d;
				end
			end
			cds_pkg::OP_NEXT: begin
				if (int'(held_day) < days_in(int'(held_year), int'(held_month)))
					held_day = held_day + 1'b1;
				else if (held_month < 12) begin
					held_month = held_month + 1'b1;
					held_day   = cds_pkg::DAY_FIRST;
				end else if (int'(held_year) < cds_pkg::YEAR_MAX) begin
					held_year  = held_year + 1'b1;
					held_month = cds_pkg::MONTH_FIRST;
					held_day   = cds_pkg::DAY_FIRST;
				end else
					r.status = cds_pkg::ST_LIMIT;
			end
			cds_pkg::OP_PREV: begin
				if (held_day > 1)
					held_day = held_day - 1'b1;
				else if (held_month > 1) begin
					held_month = held_month - 1'b1;
					held_day   = cds_pkg::day_t'(days_in(int'(held_year), int'(held_month)));
				end else if (held_year > 0) begin
					held_year  = held_year - 1'b1;
					held_month = cds_pkg::MONTH_LAST;
					held_day   = cds_pkg::DAY_LAST;
				end else
					r.status = cds_pkg::ST_LIMIT;
			end
			default: begin
				// raw field compare: year, then month, then day
				if (held_year != y)
					r.earlier = (held_year < y);
				else if (held_month != m)
					r.earlier = (held_month < m);
				else
					r.earlier = (held_day < d);
				r.equal = (held_year == y) && (held_month == m) && (held_day == d);
			end
		endcase
		r.year  = held_year;
		r.month = held_month;
		r.day   = held_day;
		return r;
	endfunction

	task automatic add_word(cds_pkg::op_t op, int y, int m, int d);
		cmd_word_t w;
		w.opcode = op;
		w.year   = cds_pkg::year_t'(y);
		w.month  = cds_pkg::month_t'(m);
		w.day    = cds_pkg::day_t'(d);
		// pause the sender until all results are back: first random word and one midway
		w.drain  = (random_start >= 0) && (pending_words.size() == random_start ||
			pending_words.size() == random_start + 200);
		pending_words.push_back(w);
	endtask

	task automatic pick_date(output int y, output int m, output int d);
		int len;
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 3))
					0: y = 0;
					1: y = 1;
					2: y = cds_pkg::YEAR_MAX - 1;
					default: y = cds_pkg::YEAR_MAX;
				endcase
			end
			1: y = $urandom_range(0, cds_pkg::YEAR_MAX / 100) * 100;
			default: y = $urandom_range(0, cds_pkg::YEAR_MAX);
		endcase
		m   = $urandom_range(1, 12);
		len = days_in(y, m);
		// lean toward month ends so steps cross months and years
		case ($urandom_range(0, 3))
			0: d = $urandom_range(1, len);
			1: d = 1;
			default: d = len - $urandom_range(0, 1);
		endcase
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// command driver
	always @(posedge clk) begin : driver
		date_reply_t r;
		cmd_word_t   w;
		if (!arst_n) begin
			cmd_bus.valid    <= 1'b0;
			cmd_bus.opcode   <= cds_pkg::OP_SET;
			cmd_bus.year_in  <= '0;
			cmd_bus.month_in <= '0;
			cmd_bus.day_in   <= '0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				r = apply_command(cmd_bus.opcode, cmd_bus.year_in, cmd_bus.month_in,
					cmd_bus.day_in);
				replies_due.push_back(r);
				words_sent <= words_sent + 1;
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (pending_words.size() != 0 &&
						!(pending_words[0].drain && replies_due.size() != 0) &&
						(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					w = pending_words.pop_front();
					cmd_bus.valid    <= 1'b1;
					cmd_bus.opcode   <= w.opcode;
					cmd_bus.year_in  <= w.year;
					cmd_bus.month_in <= w.month;
					cmd_bus.day_in   <= w.day;
				end else
					cmd_bus.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off once, so the block backs up into the command side
	always @(posedge clk) begin
		if (arst_n) begin
			if (holdoff_left != 0)
				holdoff_left <= holdoff_left - 1;
			else if (!holdoff_done && words_sent >= HOLDOFF_AFTER) begin
				holdoff_left <= HOLDOFF_LEN;
				holdoff_done <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : monitor
		date_reply_t want;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t ns: unexpected result word: expected none, actual %0d-%0d-%0d",
						$time, res_bus.year_out, res_bus.month_out, res_bus.day_out);
					errors++;
				end else begin
					want = replies_due.pop_front();
					check_field("year", want.year, res_bus.year_out);
					check_field("month", want.month, res_bus.month_out);
					check_field("day", want.day, res_bus.day_out);
					check_field("status", want.status, res_bus.status);
					check_field("is_before", want.earlier, res_bus.is_before);
					check_field("is_equal", want.equal, res_bus.is_equal);
				end
			end
			res_bus.ready <= (holdoff_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : run
		int y;
		int m;
		int d;
		int pick;
		int burst;

		// reset date, steps across the year boundary with extreme ignored fields
		add_word(cds_pkg::OP_COMPARE, 2000, 1, 1);
		add_word(cds_pkg::OP_PREV, 0, 0, 0);
		add_word(cds_pkg::OP_NEXT, 16383, 15, 31);
		// both calendar ends
		add_word(cds_pkg::OP_SET, 0, 1, 1);
		add_word(cds_pkg::OP_PREV, 0, 0, 0);
		add_word(cds_pkg::OP_NEXT, 0, 0, 0);
		add_word(cds_pkg::OP_SET, cds_pkg::YEAR_MAX, 12, 31);
		add_word(cds_pkg::OP_NEXT, 0, 0, 0);
		// year out of range wins over bad month and day; then bad months and bad days alone
		add_word(cds_pkg::OP_SET, cds_pkg::YEAR_MAX + 1, 1, 1);
		add_word(cds_pkg::OP_SET, 16383, 0, 0);
		add_word(cds_pkg::OP_SET, 2000, 0, 15);
		add_word(cds_pkg::OP_SET, 2000, 13, 1);
		add_word(cds_pkg::OP_SET, 2000, 5, 0);
		add_word(cds_pkg::OP_SET, 2001, 2, 29);
		add_word(cds_pkg::OP_SET, 1900, 2, 29);
		add_word(cds_pkg::OP_SET, 2023, 4, 31);
		// leap day in a 400-year and a plain leap year, non-leap century
		add_word(cds_pkg::OP_SET, 2000, 2, 28);
		add_word(cds_pkg::OP_NEXT, 0, 0, 0);
		add_word(cds_pkg::OP_NEXT, 0, 0, 0);
		add_word(cds_pkg::OP_PREV, 0, 0, 0);
		add_word(cds_pkg::OP_SET, 2024, 2, 29);
		add_word(cds_pkg::OP_COMPARE, 2024, 15, 31);
		add_word(cds_pkg::OP_COMPARE, 2024, 2, 0);
		add_word(cds_pkg::OP_SET, 2100, 3, 1);
		add_word(cds_pkg::OP_PREV, 0, 0, 0);

		random_start = pending_words.size();
		while (pending_words.size() < random_start + RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 12)
				add_word(cds_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 16383),
					$urandom_range(0, 15), $urandom_range(0, 31));
			else if (pick < 32) begin
				pick_date(y, m, d);
				add_word(cds_pkg::OP_SET, y, m, d);
				case ($urandom_range(0, 4))
					0: add_word(cds_pkg::OP_COMPARE, y, m, d);
					1: add_word(cds_pkg::OP_COMPARE, y, m, d + $urandom_range(0, 1));
					2: add_word(cds_pkg::OP_COMPARE, y, m, d - $urandom_range(0, 1));
					default: ;
				endcase
			end else if (pick < 36) begin
				pick_date(y, m, d);
				add_word(cds_pkg::OP_SET, y, $urandom_range(0, 15), $urandom_range(0, 31));
			end else if (pick < 64) begin
				burst = $urandom_range(1, 5);
				repeat (burst)
					add_word(cds_pkg::OP_NEXT, $urandom_range(0, 16383), $urandom_range(0, 15),
						$urandom_range(0, 31));
			end else if (pick < 92) begin
				burst = $urandom_range(1, 5);
				repeat (burst)
					add_word(cds_pkg::OP_PREV, $urandom_range(0, 16383), $urandom_range(0, 15),
						$urandom_range(0, 31));
			end else begin
				pick_date(y, m, d);
				add_word(cds_pkg::OP_COMPARE, y, m, d);
			end
		end

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || cmd_bus.valid)
			@(posedge clk);
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
